// ===== design/fprx_pkg.sv =====
// Package for the framed packet receiver.
// Holds framing constants, result codes, the result struct and the CRC-8 fold.
// No dependencies; used by fprx_core, fprx_out_stage and the top level.
`default_nettype none

package fprx_pkg;

  // Framing bytes
  localparam logic [7:0] FEND  = 8'hC0;
  localparam logic [7:0] FESC  = 8'hDB;
  localparam logic [7:0] TFEND = 8'hDC;
  localparam logic [7:0] TFESC = 8'hDD;

  // CRC constants (reflected Dallas/1-Wire)
  localparam logic [7:0] CRC_TAP    = 8'h18;
  localparam logic [7:0] SEED_RESET = 8'hDE;
  localparam logic [7:0] TOP_BIT    = 8'h80;
  localparam logic [7:0] LOW7       = 8'h7F;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CAUSE_ESC = 2'd0,
    CAUSE_CMD = 2'd1,
    CAUSE_CRC = 2'd2
  } cause_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [7:0] data_index;
    logic [6:0] address;
    logic [6:0] command;
    logic [7:0] length;
    cause_t     reject_cause;
  } res_t;

  // One byte through the reflected CRC-8, LSB first
  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ b[k]) begin
        c = ((c ^ CRC_TAP) >> 1) | TOP_BIT;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/fprx_rx_if.sv =====
// Input channel of the framed packet receiver: one raw byte per transfer.
// Stand-alone interface, no dependencies.
`default_nettype none

interface fprx_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== design/fprx_res_if.sv =====
// Result channel of the framed packet receiver: one report per transfer.
// Stand-alone interface, no dependencies.
`default_nettype none

interface fprx_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [7:0] data_index;
  logic [6:0] address;
  logic [6:0] command;
  logic [7:0] length;
  logic [1:0] reject_cause;

  modport source (output valid, output kind, output data_byte, output data_index,
                  output address, output command, output length, output reject_cause,
                  input ready);
  modport sink   (input valid, input kind, input data_byte, input data_index,
                  input address, input command, input length, input reject_cause,
                  output ready);
endinterface

`default_nettype wire

// ===== design/fprx_in_stage.sv =====
// Input register of the framed packet receiver.
// Depends on fprx_rx_if; holds one accepted byte until the core takes it.
`default_nettype none

module fprx_in_stage (
  input  wire logic   clk,
  input  wire logic   rst,
  fprx_rx_if.sink     rx,
  input  wire logic   advance,
  output logic        byte_vld,
  output logic [7:0]  byte_q
);

  // Accept when empty or when the held byte moves on this cycle
  assign rx.ready = !byte_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_vld <= 1'b0;
    end else if (rx.ready) begin
      byte_vld <= rx.valid;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      byte_q <= rx.rx_byte;
    end
  end

endmodule

`default_nettype wire

// ===== design/fprx_core.sv =====
// Frame decoder: hunt, unescape, header/payload parsing and CRC-8 check.
// Depends on fprx_pkg; processes one byte per step and yields at most one result.
`default_nettype none

module fprx_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic [7:0]  in_byte,
  input  wire logic [7:0]  crc_seed,
  output logic             res_vld,
  output fprx_pkg::res_t   res
);

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_FIRST = 3'd1,
    PH_CMD   = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4,
    PH_CRC   = 3'd5
  } phase_t;

  phase_t     phase, phase_next;
  logic       escape_pending, escape_pending_next;
  logic [7:0] crc_reg, crc_reg_next;
  logic [6:0] addr_reg, addr_reg_next;
  logic [6:0] cmd_reg, cmd_reg_next;
  logic [7:0] len_reg, len_reg_next;
  logic [7:0] byte_count, byte_count_next;

  logic [7:0] b;
  logic       take;
  logic [7:0] crc_src;
  logic [7:0] fold_byte;
  logic [7:0] crc_calc;
  logic [7:0] count_inc;

  // Single CRC fold; operands chosen by phase
  always_comb begin
    b = in_byte;
    if (escape_pending) begin
      if (in_byte == fprx_pkg::TFEND) begin
        b = fprx_pkg::FEND;
      end else if (in_byte == fprx_pkg::TFESC) begin
        b = fprx_pkg::FESC;
      end
    end
    if (phase == PH_HUNT) begin
      crc_src   = crc_seed;
      fold_byte = fprx_pkg::FEND;
    end else begin
      crc_src   = crc_reg;
      // First byte (address or command) enters the CRC with bit 7 cleared
      fold_byte = (phase == PH_FIRST) ? (b & fprx_pkg::LOW7) : b;
    end
    crc_calc  = fprx_pkg::crc_fold(crc_src, fold_byte);
    count_inc = byte_count + 8'd1;
  end

  // Next state and result
  always_comb begin
    phase_next          = phase;
    escape_pending_next = escape_pending;
    crc_reg_next        = crc_reg;
    addr_reg_next       = addr_reg;
    cmd_reg_next        = cmd_reg;
    len_reg_next        = len_reg;
    byte_count_next     = byte_count;
    take                = 1'b0;
    res_vld             = 1'b0;
    res.kind            = fprx_pkg::KIND_DATA;
    res.data_byte       = 8'd0;
    res.data_index      = 8'd0;
    res.address         = addr_reg;
    res.command         = cmd_reg;
    res.length          = len_reg;
    res.reject_cause    = fprx_pkg::CAUSE_ESC;

    if (phase == PH_HUNT) begin
      // Frame end starts a frame
      if (in_byte == fprx_pkg::FEND) begin
        crc_reg_next        = crc_calc;
        addr_reg_next       = 7'd0;
        cmd_reg_next        = 7'd0;
        len_reg_next        = 8'd0;
        byte_count_next     = 8'd0;
        escape_pending_next = 1'b0;
        phase_next          = PH_FIRST;
      end
    end else if (escape_pending) begin
      escape_pending_next = 1'b0;
      if (in_byte == fprx_pkg::TFEND || in_byte == fprx_pkg::TFESC) begin
        take = 1'b1;
      end else begin
        // Bad escape: byte consumed, frame rejected
        phase_next       = PH_HUNT;
        res_vld          = 1'b1;
        res.kind         = fprx_pkg::KIND_REJECT;
        res.reject_cause = fprx_pkg::CAUSE_ESC;
      end
    end else if (in_byte == fprx_pkg::FESC) begin
      escape_pending_next = 1'b1;
    end else begin
      take = 1'b1;
    end

    if (take) begin
      unique case (phase)
        PH_FIRST: begin
          crc_reg_next = crc_calc;
          if (b[7]) begin
            addr_reg_next = b[6:0];
            phase_next    = PH_CMD;
          end else begin
            cmd_reg_next = b[6:0];
            phase_next   = PH_LEN;
          end
        end
        PH_CMD: begin
          if (b[7]) begin
            phase_next       = PH_HUNT;
            res_vld          = 1'b1;
            res.kind         = fprx_pkg::KIND_REJECT;
            res.reject_cause = fprx_pkg::CAUSE_CMD;
          end else begin
            cmd_reg_next = b[6:0];
            crc_reg_next = crc_calc;
            phase_next   = PH_LEN;
          end
        end
        PH_LEN: begin
          len_reg_next    = b;
          byte_count_next = 8'd0;
          crc_reg_next    = crc_calc;
          phase_next      = (b != 8'd0) ? PH_DATA : PH_CRC;
        end
        PH_DATA: begin
          crc_reg_next    = crc_calc;
          byte_count_next = count_inc;
          if (count_inc == len_reg) begin
            phase_next = PH_CRC;
          end
          res_vld        = 1'b1;
          res.kind       = fprx_pkg::KIND_DATA;
          res.data_byte  = b;
          res.data_index = byte_count;
        end
        PH_CRC: begin
          crc_reg_next = crc_calc;
          phase_next   = PH_HUNT;
          res_vld      = 1'b1;
          if (crc_calc == 8'd0) begin
            res.kind = fprx_pkg::KIND_ACCEPT;
          end else begin
            res.kind         = fprx_pkg::KIND_REJECT;
            res.reject_cause = fprx_pkg::CAUSE_CRC;
          end
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      escape_pending <= 1'b0;
      crc_reg        <= fprx_pkg::SEED_RESET;
      addr_reg       <= 7'd0;
      cmd_reg        <= 7'd0;
      len_reg        <= 8'd0;
      byte_count     <= 8'd0;
    end else if (step) begin
      phase          <= phase_next;
      escape_pending <= escape_pending_next;
      crc_reg        <= crc_reg_next;
      addr_reg       <= addr_reg_next;
      cmd_reg        <= cmd_reg_next;
      len_reg        <= len_reg_next;
      byte_count     <= byte_count_next;
    end
  end

  // Checks
  a_hunt_no_esc: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HUNT |-> !escape_pending)
    else $error("escape pending while hunting");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> byte_count < len_reg)
    else $error("payload count past declared length");

  a_data_only_in_payload: assert property (@(posedge clk) disable iff (rst)
    res_vld && res.kind == fprx_pkg::KIND_DATA |-> phase == PH_DATA)
    else $error("payload result outside payload phase");

  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_HUNT && in_byte == fprx_pkg::FEND |=> phase == PH_FIRST)
    else $error("frame end did not start a frame");

endmodule

`default_nettype wire

// ===== design/fprx_out_stage.sv =====
// Result register of the framed packet receiver.
// Depends on fprx_pkg and fprx_res_if; holds one result until it is taken.
`default_nettype none

module fprx_out_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       load,
  input  fprx_pkg::res_t  res_in,
  output logic            free,
  fprx_res_if.source      res
);

  logic           res_vld;
  fprx_pkg::res_t res_q;

  // Room for a new result when empty or draining this cycle
  assign free = !res_vld || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (load) begin
      res_vld <= 1'b1;
    end else if (res.ready) begin
      res_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res_in;
    end
  end

  assign res.valid        = res_vld;
  assign res.kind         = res_q.kind;
  assign res.data_byte    = res_q.data_byte;
  assign res.data_index   = res_q.data_index;
  assign res.address      = res_q.address;
  assign res.command      = res_q.command;
  assign res.length       = res_q.length;
  assign res.reject_cause = res_q.reject_cause;

endmodule

`default_nettype wire

// ===== design/framed_packet_receiver_top.sv =====
// Top level of the framed packet receiver: input register, decoder, result register.
// Depends on fprx_pkg, fprx_rx_if, fprx_res_if, fprx_in_stage, fprx_core, fprx_out_stage.
//
//   channel   direction  payload                                        transfer when
//   rx        in         rx_byte[7:0]                                   rx.valid & rx.ready
//   res       out        kind, data_byte, data_index, address,          res.valid & res.ready
//                        command, length, reject_cause
//   cfg       in         cfg_wdata[7:0] -> crc_seed                     cfg_we
//
// One byte per cycle sustained while results are taken; a byte enters the input register
// at its transfer, and its result is loaded into the result register as the decoder takes it.
// The decoder's single CRC-8 fold sits between the input and result registers.
// Reset (rst, synchronous) empties both registers, starts hunting, seed 0xDE.
// A held result that is not taken stalls the decoder for every byte, with or without
// a result; rx.ready then drops once the input register holds a byte.
`default_nettype none

module framed_packet_receiver_top (
  input  wire logic       clk,
  input  wire logic       rst,
  fprx_rx_if.sink         rx,
  fprx_res_if.source      res,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);

  logic           byte_vld;
  logic [7:0]     byte_q;
  logic           advance;
  logic           out_free;
  logic           core_res_vld;
  fprx_pkg::res_t core_res;
  logic [7:0]     crc_seed;

  // Seed register
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_seed <= fprx_pkg::SEED_RESET;
    end else if (cfg_we) begin
      crc_seed <= cfg_wdata;
    end
  end

  // Held byte moves on when the result register has room
  assign advance = byte_vld && out_free;

  fprx_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx),
    .advance  (advance),
    .byte_vld (byte_vld),
    .byte_q   (byte_q)
  );

  fprx_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .in_byte  (byte_q),
    .crc_seed (crc_seed),
    .res_vld  (core_res_vld),
    .res      (core_res)
  );

  fprx_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (advance && core_res_vld),
    .res_in (core_res),
    .free   (out_free),
    .res    (res)
  );

endmodule

`default_nettype wire
